// ===== sv/mhpq_pkg.sv =====
// Shared types, constants and codes for the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned VAL_W        = 31;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned TDATA_W      = 32;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_POPPED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // Request kinds
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS_START,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_PUT_HOLD,
        OP_POP_READ,
        OP_POP_LOAD,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_POP_RD,
        ST_POP_LD,
        ST_DN_CHK,
        ST_DN_CMP,
        ST_EMIT_POP,
        ST_EMIT_EMPTY,
        ST_EMIT_FULL
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_gt1;
        logic up_move;
        logic dn_has_child;
        logic dn_move;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/mhpq_ctrl.sv =====
// Sequencing state machine for insert sift-up and pop sift-down.
`default_nettype none

module mhpq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_cmd,
    output logic                   in_ready,
    input  wire mhpq_pkg::dp_stat_t stat,
    output mhpq_pkg::dp_cmd_t      cmd
);

    mhpq_pkg::state_t state_reg;
    mhpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = mhpq_pkg::OP_NONE;
        cmd.res_status = mhpq_pkg::STATUS_POPPED;
        in_ready       = 1'b0;
        unique case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == mhpq_pkg::CMD_INSERT)
                    begin
                        if (stat.full)
                        begin
                            state_next = mhpq_pkg::ST_EMIT_FULL;
                        end
                        else
                        begin
                            cmd.op     = mhpq_pkg::OP_INS_START;
                            state_next = mhpq_pkg::ST_UP_CHK;
                        end
                    end
                    else if (stat.empty)
                    begin
                        state_next = mhpq_pkg::ST_EMIT_EMPTY;
                    end
                    else
                    begin
                        state_next = mhpq_pkg::ST_POP_RD;
                    end
                end
            end
            mhpq_pkg::ST_UP_CHK:
            begin
                if (stat.pos_gt1)
                begin
                    cmd.op     = mhpq_pkg::OP_UP_READ;
                    state_next = mhpq_pkg::ST_UP_CMP;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_PUT_HOLD;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            mhpq_pkg::ST_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    cmd.op     = mhpq_pkg::OP_UP_MOVE;
                    state_next = mhpq_pkg::ST_UP_CHK;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_PUT_HOLD;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            mhpq_pkg::ST_POP_RD:
            begin
                cmd.op     = mhpq_pkg::OP_POP_READ;
                state_next = mhpq_pkg::ST_POP_LD;
            end
            mhpq_pkg::ST_POP_LD:
            begin
                cmd.op     = mhpq_pkg::OP_POP_LOAD;
                state_next = mhpq_pkg::ST_DN_CHK;
            end
            mhpq_pkg::ST_DN_CHK:
            begin
                if (stat.dn_has_child)
                begin
                    cmd.op     = mhpq_pkg::OP_DN_READ;
                    state_next = mhpq_pkg::ST_DN_CMP;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_PUT_HOLD;
                    state_next = mhpq_pkg::ST_EMIT_POP;
                end
            end
            mhpq_pkg::ST_DN_CMP:
            begin
                if (stat.dn_move)
                begin
                    cmd.op     = mhpq_pkg::OP_DN_MOVE;
                    state_next = mhpq_pkg::ST_DN_CHK;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_PUT_HOLD;
                    state_next = mhpq_pkg::ST_EMIT_POP;
                end
            end
            mhpq_pkg::ST_EMIT_POP:
            begin
                cmd.res_status = mhpq_pkg::STATUS_POPPED;
                if (stat.out_free)
                begin
                    cmd.op     = mhpq_pkg::OP_EMIT;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            mhpq_pkg::ST_EMIT_EMPTY:
            begin
                cmd.res_status = mhpq_pkg::STATUS_EMPTY;
                if (stat.out_free)
                begin
                    cmd.op     = mhpq_pkg::OP_EMIT;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            mhpq_pkg::ST_EMIT_FULL:
            begin
                cmd.res_status = mhpq_pkg::STATUS_FULL;
                if (stat.out_free)
                begin
                    cmd.op     = mhpq_pkg::OP_EMIT;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mhpq_datapath.sv =====
// Heap store, entry count, sift registers and the result register.
`default_nettype none

module mhpq_datapath
#(
    parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mhpq_pkg::dp_cmd_t             cmd,
    output mhpq_pkg::dp_stat_t                 stat,
    input  wire logic [mhpq_pkg::VAL_W-1:0]    in_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [mhpq_pkg::VAL_W-1:0]         out_value,
    output logic [mhpq_pkg::STATUS_W-1:0]      out_status
);

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned VAL_W  = mhpq_pkg::VAL_W;

    logic [VAL_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0]    hold_reg, hold_next;
    logic [VAL_W-1:0]    top_reg, top_next;
    logic [VAL_W-1:0]    rd0_reg, rd1_reg;
    logic                out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic [mhpq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [CNT_W:0]      lpos, rpos, count_ext;
    logic                has_right, take_l, take_r;
    logic                re;
    logic [ADDR_W-1:0]   raddr0, raddr1, waddr, pos_addr;
    logic                we;
    logic [VAL_W-1:0]    wdata;
    logic [CNT_W-1:0]    parent, cnt_last;

    assign count_ext = {1'b0, count_reg};
    assign lpos      = {pos_reg, 1'b0};
    assign rpos      = {pos_reg, 1'b1};
    assign has_right = rpos <= count_ext;
    assign take_l    = (!has_right || (rd0_reg > rd1_reg)) && (rd0_reg > hold_reg);
    assign take_r    = !take_l && has_right && (rd1_reg > hold_reg);
    assign parent    = pos_reg >> 1;
    assign cnt_last  = count_reg - CNT_W'(1);
    assign pos_addr  = ADDR_W'(pos_reg - CNT_W'(1));

    always_comb
    begin
        stat.full         = count_reg == CNT_W'(CAPACITY);
        stat.empty        = count_reg == '0;
        stat.pos_gt1      = pos_reg > CNT_W'(1);
        stat.up_move      = rd0_reg < hold_reg;
        stat.dn_has_child = lpos <= count_ext;
        stat.dn_move      = take_l || take_r;
        stat.out_free     = !out_valid_reg || out_ready;
    end

    // Memory ports and register updates per command
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        hold_next       = hold_reg;
        top_next        = top_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        re              = 1'b0;
        raddr0          = pos_addr;
        raddr1          = pos_addr;
        we              = 1'b0;
        waddr           = pos_addr;
        wdata           = hold_reg;
        unique case (cmd.op)
            mhpq_pkg::OP_NONE:
            begin
            end
            mhpq_pkg::OP_INS_START:
            begin
                hold_next  = in_value;
                count_next = count_reg + CNT_W'(1);
                pos_next   = count_reg + CNT_W'(1);
            end
            mhpq_pkg::OP_UP_READ:
            begin
                re     = 1'b1;
                raddr0 = ADDR_W'(parent - CNT_W'(1));
            end
            mhpq_pkg::OP_UP_MOVE:
            begin
                // parent drops into the hole, hole moves up
                we       = 1'b1;
                wdata    = rd0_reg;
                pos_next = parent;
            end
            mhpq_pkg::OP_PUT_HOLD:
            begin
                we = 1'b1;
            end
            mhpq_pkg::OP_POP_READ:
            begin
                re     = 1'b1;
                raddr0 = '0;
                raddr1 = ADDR_W'(cnt_last);
            end
            mhpq_pkg::OP_POP_LOAD:
            begin
                top_next   = rd0_reg;
                hold_next  = rd1_reg;
                count_next = cnt_last;
                pos_next   = CNT_W'(1);
            end
            mhpq_pkg::OP_DN_READ:
            begin
                re     = 1'b1;
                raddr0 = ADDR_W'(lpos - (CNT_W + 1)'(1));
                raddr1 = ADDR_W'(lpos);
            end
            mhpq_pkg::OP_DN_MOVE:
            begin
                // larger child rises into the hole, hole moves down
                we = 1'b1;
                if (take_l)
                begin
                    wdata    = rd0_reg;
                    pos_next = CNT_W'(lpos);
                end
                else
                begin
                    wdata    = rd1_reg;
                    pos_next = CNT_W'(rpos);
                end
            end
            mhpq_pkg::OP_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = cmd.res_status;
                out_value_next  = (cmd.res_status == mhpq_pkg::STATUS_POPPED) ? top_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd0_reg <= mem[raddr0];
            rd1_reg <= mem[raddr1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        hold_reg       <= hold_next;
        top_reg        <= top_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// ===== sv/max_heap_priority_queue_top.sv =====
// Max-heap priority queue: one request at a time, heap held in on-chip memory.
// Insert sifts the new value up level by level until it reaches the root or meets a parent
// that is not smaller. Pop reads the root and the last entry, then sifts down level by level
// until no child is larger. Dropped inserts and empty pops go straight to their result.
// Results wait in an output register; a new request may enter, but its result waits until that is free.
// Reset (async, active low) empties the heap; memory contents are not cleared.
`default_nettype none

module max_heap_priority_queue_top
#(
    parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [mhpq_pkg::TDATA_W-1:0]  s_axis_tdata,  // [30:0] value, [31] zero
    input  wire logic                          s_axis_tuser,  // [0] command
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [mhpq_pkg::TDATA_W-1:0]       m_axis_tdata,  // [30:0] result_value, [31] zero
    output logic [mhpq_pkg::STATUS_W-1:0]      m_axis_tuser   // [1:0] status
);

    mhpq_pkg::dp_cmd_t  cmd;
    mhpq_pkg::dp_stat_t stat;
    logic [mhpq_pkg::VAL_W-1:0] out_value;

    mhpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_value   (s_axis_tdata[mhpq_pkg::VAL_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (out_value),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {{(mhpq_pkg::TDATA_W - mhpq_pkg::VAL_W){1'b0}}, out_value};

endmodule

`default_nettype wire

// ===== tb/max_heap_priority_queue_top_test.sv =====
// Self-checking testbench for the max-heap priority queue with a shadow heap predictor.
`timescale 1ns / 1ps

module max_heap_priority_queue_top_test;

    localparam int unsigned DEPTH       = mhpq_pkg::CAPACITY_DEF;
    localparam int unsigned VAL_W       = mhpq_pkg::VAL_W;
    localparam int unsigned STATUS_W    = mhpq_pkg::STATUS_W;
    localparam int unsigned TDATA_W     = mhpq_pkg::TDATA_W;
    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int unsigned DRAIN_WAIT  = 48;
    localparam int unsigned IDLE_PCT    = 8;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [STATUS_W-1:0] status;
    } heap_result_t;

    // Shadow copy of the heap; queues the answer each accepted pop or refused insert should produce
    class heap_shadow;
        logic [VAL_W-1:0] slot [1:DEPTH];
        int unsigned      fill = 0;
        heap_result_t     pending [$];
        int unsigned      faults = 0;

        function void lift(int unsigned start);
            int unsigned  pos;
            logic [VAL_W-1:0] t;
            pos = start;
            while (pos > 1 && slot[pos / 2] < slot[pos]) begin
                t             = slot[pos];
                slot[pos]     = slot[pos / 2];
                slot[pos / 2] = t;
                pos           = pos / 2;
            end
        endfunction

        function void sink();
            int unsigned      pos;
            int unsigned      lpos;
            int unsigned      rpos;
            int unsigned      nxt;
            bit               has_right;
            logic [VAL_W-1:0] cur;
            logic [VAL_W-1:0] lv;
            logic [VAL_W-1:0] rv;
            pos = 1;
            while (pos * 2 <= fill) begin
                lpos      = pos * 2;
                rpos      = lpos + 1;
                has_right = (rpos <= fill);
                cur       = slot[pos];
                lv        = slot[lpos];
                rv        = has_right ? slot[rpos] : '0;
                // on equal children the right one wins
                if ((!has_right || lv > rv) && lv > cur)
                    nxt = lpos;
                else if (has_right && rv > cur)
                    nxt = rpos;
                else
                    break;
                slot[pos] = slot[nxt];
                slot[nxt] = cur;
                pos       = nxt;
            end
        endfunction

        function void apply_request(logic cmd, logic [VAL_W-1:0] val);
            heap_result_t r;
            if (cmd == mhpq_pkg::CMD_INSERT) begin
                if (fill >= DEPTH) begin
                    r.value  = '0;
                    r.status = mhpq_pkg::STATUS_FULL;
                    pending.push_back(r);
                end
                else begin
                    fill++;
                    slot[fill] = val;
                    lift(fill);
                end
            end
            else if (fill == 0) begin
                r.value  = '0;
                r.status = mhpq_pkg::STATUS_EMPTY;
                pending.push_back(r);
            end
            else begin
                r.value  = slot[1];
                r.status = mhpq_pkg::STATUS_POPPED;
                slot[1]  = slot[fill];
                fill--;
                sink();
                pending.push_back(r);
            end
        endfunction

        function void match_result(logic [VAL_W-1:0] value, logic [STATUS_W-1:0] status);
            heap_result_t exp_r;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected result value %0d status %0d",
                             $realtime, value, status);
            end
            else begin
                exp_r = pending.pop_front();
                if (exp_r.value !== value || exp_r.status !== status) begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: expected value %0d status %0d, got value %0d status %0d",
                                 $realtime, exp_r.value, exp_r.status, value, status);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata;   // [30:0] value, [31] zero
    logic                s_axis_tuser;   // [0] command
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;   // [30:0] result_value, [31] zero
    logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status

    heap_shadow  shadow = new();
    bit          no_gaps = 1'b0;
    int unsigned cycle_count = 0;

    max_heap_priority_queue_top #(.CAPACITY(DEPTH)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.match_result(m_axis_tdata[VAL_W-1:0], m_axis_tuser);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Call at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic cmd, input logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = 0;
        if (!no_gaps)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        shadow.apply_request(cmd, val);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(15);
        // small range forces ties between siblings and with the moved entry
        if (sel < 5)
            return VAL_W'($urandom_range(15));
        if (sel == 5)
            return '0;
        if (sel == 6)
            return '1;
        return VAL_W'($urandom);
    endfunction

    task automatic run_mix(input int unsigned count, input int unsigned pop_pct);
        logic cmd;
        repeat (count) begin
            cmd = ($urandom_range(99) < pop_pct) ? mhpq_pkg::CMD_POP : mhpq_pkg::CMD_INSERT;
            send_request(cmd, pick_value());
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mhpq_pkg::CMD_INSERT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, extremes, zero, ties, drain past empty
        send_request(mhpq_pkg::CMD_POP, 31'h7FFF_FFFF);
        send_request(mhpq_pkg::CMD_INSERT, 31'h0000_0000);
        send_request(mhpq_pkg::CMD_INSERT, 31'h7FFF_FFFF);
        send_request(mhpq_pkg::CMD_INSERT, 31'h0000_0001);
        send_request(mhpq_pkg::CMD_INSERT, 31'h4000_0000);
        send_request(mhpq_pkg::CMD_INSERT, 31'h2AAA_AAAA);
        send_request(mhpq_pkg::CMD_INSERT, 31'h5555_5555);
        send_request(mhpq_pkg::CMD_INSERT, 31'h0000_0007);
        send_request(mhpq_pkg::CMD_INSERT, 31'h0000_0007);
        send_request(mhpq_pkg::CMD_INSERT, 31'h0000_0007);
        send_request(mhpq_pkg::CMD_POP, 31'h0);
        send_request(mhpq_pkg::CMD_POP, 31'h0);
        send_request(mhpq_pkg::CMD_INSERT, 31'h7FFF_FFFF);
        repeat (9) send_request(mhpq_pkg::CMD_POP, 31'h0);
        send_request(mhpq_pkg::CMD_POP, 31'h2AAA_AAAA);

        // Random: mixed traffic, fill past capacity, churn near full, drain
        run_mix(200, 40);
        no_gaps = 1'b1;
        while (shadow.fill < DEPTH)
            send_request(mhpq_pkg::CMD_INSERT, pick_value());
        run_mix(30, 0);
        no_gaps = 1'b0;
        run_mix(200, 50);
        run_mix(500, 75);

        s_axis_tvalid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (shadow.faults == 0 && shadow.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
